/* rtl/gnpe_pkg.sv */
`timescale 1ns / 1ps
package gnpe_pkg;

  localparam int CELLS_X_DEF = 16;
  localparam int CELLS_Y_DEF = 16;
  localparam int MAX_SPLIT   = 255;
  localparam int Q_DEPTH     = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic REG_SAMPLES = 1'b0;
  localparam logic REG_STEP    = 1'b1;

  localparam logic [7:0]  SAMPLES_RST = 8'd2;
  localparam logic [15:0] STEP_RST    = 16'd21845;

  typedef struct packed {
    logic               operation;
    logic [4:0]         cell_x;
    logic [4:0]         cell_y;
    logic [7:0]         sub_x;
    logic [7:0]         sub_y;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
  } gnpe_in_t;

  typedef struct packed {
    logic signed [15:0] noise_value;
    logic               out_of_range;
  } gnpe_out_t;

  // one classified item between front and back
  typedef struct packed {
    logic               wr;
    logic               ev;
    logic               oor;
    logic [4:0]         cell_x;
    logic [4:0]         cell_y;
    logic [15:0]        t_x;
    logic [15:0]        t_y;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
  } gnpe_task_t;

endpackage

/* rtl/gnpe_ram.sv */
`timescale 1ns / 1ps
module gnpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 81,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/gnpe_front.sv */
`timescale 1ns / 1ps
module gnpe_front import gnpe_pkg::*; #(
  parameter int CELLS_X = CELLS_X_DEF,
  parameter int CELLS_Y = CELLS_Y_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  gnpe_in_t   in_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [15:0] cfg_data,
  output logic       task_valid,
  output gnpe_task_t task_data
);

  logic [7:0]  samples_r;
  logic [15:0] step_r;
  logic [7:0]  split;
  logic [24:0] frac_x;
  logic [24:0] frac_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r <= SAMPLES_RST;
      step_r    <= STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SAMPLES: samples_r <= cfg_data[7:0];
        REG_STEP:    step_r    <= cfg_data;
        default:     step_r    <= step_r;
      endcase
    end
  end

  always_comb begin
    split  = (samples_r < 8'(MAX_SPLIT)) ? samples_r : 8'(MAX_SPLIT);
    frac_x = 25'(({1'b0, in_data.sub_x} + 9'd1) * step_r);
    frac_y = 25'(({1'b0, in_data.sub_y} + 9'd1) * step_r);

    task_valid       = in_valid;
    task_data.ev     = (in_data.operation == OP_EVAL);
    task_data.wr     = (in_data.operation == OP_LOAD) &&
                       (int'(in_data.cell_x) <= CELLS_X) &&
                       (int'(in_data.cell_y) <= CELLS_Y);
    task_data.oor    = (int'(in_data.cell_x) >= CELLS_X) ||
                       (int'(in_data.cell_y) >= CELLS_Y) ||
                       (in_data.sub_x >= split) || (in_data.sub_y >= split);
    task_data.cell_x = in_data.cell_x;
    task_data.cell_y = in_data.cell_y;
    // fraction saturates just below one
    task_data.t_x    = (|frac_x[24:16]) ? 16'hFFFF : frac_x[15:0];
    task_data.t_y    = (|frac_y[24:16]) ? 16'hFFFF : frac_y[15:0];
    task_data.grad_x = in_data.grad_x;
    task_data.grad_y = in_data.grad_y;
  end

endmodule

/* rtl/gnpe_queue.sv */
`timescale 1ns / 1ps
module gnpe_queue import gnpe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  gnpe_task_t push_data,
  output logic       full,
  output logic       head_valid,
  output gnpe_task_t head_data,
  input  logic       pop
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  gnpe_task_t     slot_r [Q_DEPTH];
  logic [PW-1:0]  wptr_r;
  logic [PW-1:0]  rptr_r;
  logic [CW-1:0]  count_r;
  logic           push;

  assign full       = (count_r == CW'(Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = slot_r[rptr_r];
  assign push       = push_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(Q_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(Q_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(Q_DEPTH)) else $error("queue count past depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1) else $error("queue count lost a push");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("pop from empty queue");

endmodule

/* rtl/gnpe_back.sv */
`timescale 1ns / 1ps
module gnpe_back import gnpe_pkg::*; #(
  parameter int CELLS_X = CELLS_X_DEF,
  parameter int CELLS_Y = CELLS_Y_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  gnpe_task_t head_data,
  output logic       pop,
  input  logic       out_stall,
  output logic       out_valid,
  output gnpe_out_t  out_data
);

  // lattice split in four banks by x and y parity: the four corners
  // of any cell sit in four different banks
  localparam int BX = (CELLS_X + 2) / 2;
  localparam int BY = (CELLS_Y + 2) / 2;
  localparam int BD = BX * BY;
  localparam int AW = (BD > 1) ? $clog2(BD) : 1;

  logic adv;
  logic out_valid_r;
  gnpe_out_t out_data_r;

  assign adv       = !out_valid_r || !out_stall;
  assign pop       = adv && head_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // bank access at pop
  logic [4:0]    xi [2];
  logic [4:0]    yi [2];
  logic [31:0]   rd [4];

  always_comb begin
    xi[0] = 5'(({1'b0, head_data.cell_x} + 6'd1) >> 1);
    xi[1] = head_data.cell_x >> 1;
    yi[0] = 5'(({1'b0, head_data.cell_y} + 6'd1) >> 1);
    yi[1] = head_data.cell_y >> 1;
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [AW-1:0] addr;
    logic          we;
    assign addr = AW'(int'(xi[b / 2]) * BY + int'(yi[b % 2]));
    assign we   = pop && head_data.wr && (head_data.cell_x[0] == 1'(b / 2)) &&
                  (head_data.cell_y[0] == 1'(b % 2));
    gnpe_ram #(.WIDTH(32), .DEPTH(BD), .AW(AW)) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(addr),
      .wdata({head_data.grad_y, head_data.grad_x}),
      .re   (adv),
      .raddr(addr),
      .rdata(rd[b])
    );
  end

  // stage 1
  logic        vld1_r, oor1_r, px1_r, py1_r;
  logic [15:0] tx1_r, ty1_r;
  logic [31:0] ttx1_r, tty1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= pop && head_data.ev;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor1_r <= head_data.oor;
      px1_r  <= head_data.cell_x[0];
      py1_r  <= head_data.cell_y[0];
      tx1_r  <= head_data.t_x;
      ty1_r  <= head_data.t_y;
      ttx1_r <= head_data.t_x * head_data.t_x;
      tty1_r <= head_data.t_y * head_data.t_y;
    end
  end

  // stage 1 -> 2: corner dots, fade first half
  logic signed [34:0] dot_c [4];
  logic [19:0]        q_x, q_y;
  logic [31:0]        t3p_x, t3p_y;

  function automatic logic [19:0] fade_q(input logic [15:0] t, input logic [31:0] tt);
    logic [34:0] six;
    logic [18:0] r6;
    six = 35'(tt) * 35'd6 + 35'd32768;
    r6  = six[34:16];
    return 20'(21'd655360 - 21'(t * 20'd15) + 21'(r6));
  endfunction

  function automatic logic [15:0] round_hi(input logic [31:0] v);
    logic [32:0] s;
    s = {1'b0, v} + 33'd32768;
    return s[31:16];
  endfunction

  always_comb begin
    logic [1:0]         bk;
    logic               hx, hy;
    logic signed [31:0] gv;
    logic signed [17:0] dx, dy;
    logic signed [33:0] pa, pb;
    for (int c = 0; c < 4; c++) begin
      hx = 1'(c / 2);
      hy = 1'(c % 2);
      bk = {px1_r ^ hx, py1_r ^ hy};
      gv = rd[bk];
      dx = hx ? $signed({2'b11, tx1_r}) : $signed({2'b00, tx1_r});
      dy = hy ? $signed({2'b11, ty1_r}) : $signed({2'b00, ty1_r});
      pa = $signed(gv[15:0]) * dx;
      pb = $signed(gv[31:16]) * dy;
      dot_c[c] = 35'(pa) + 35'(pb);
    end
    q_x   = fade_q(tx1_r, ttx1_r);
    q_y   = fade_q(ty1_r, tty1_r);
    t3p_x = round_hi(ttx1_r) * tx1_r;
    t3p_y = round_hi(tty1_r) * ty1_r;
  end

  logic               vld2_r, oor2_r;
  logic signed [34:0] dot2_r [4];
  logic [19:0]        q2x_r, q2y_r;
  logic [31:0]        t3p2x_r, t3p2y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor2_r  <= oor1_r;
      dot2_r  <= dot_c;
      q2x_r   <= q_x;
      q2y_r   <= q_y;
      t3p2x_r <= t3p_x;
      t3p2y_r <= t3p_y;
    end
  end

  // stage 3: t3 * q
  logic               vld3_r, oor3_r;
  logic signed [34:0] dot3_r [4];
  logic [35:0]        fp3x_r, fp3y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (adv) begin
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor3_r <= oor2_r;
      dot3_r <= dot2_r;
      fp3x_r <= round_hi(t3p2x_r) * q2x_r;
      fp3y_r <= round_hi(t3p2y_r) * q2y_r;
    end
  end

  // stage 4: fade cap, first lerp products
  function automatic logic [16:0] fade_fin(input logic [35:0] fp);
    logic [36:0] s;
    logic [20:0] f;
    s = {1'b0, fp} + 37'd32768;
    f = s[36:16];
    return (f > 21'd65536) ? 17'd65536 : f[16:0];
  endfunction

  logic [16:0]        fx4, fy4;
  logic signed [35:0] dbot, dtop;

  always_comb begin
    fx4  = fade_fin(fp3x_r);
    fy4  = fade_fin(fp3y_r);
    dbot = 36'(dot3_r[2]) - 36'(dot3_r[1 - 1]);
    dtop = 36'(dot3_r[3]) - 36'(dot3_r[1]);
  end

  logic               vld4_r, oor4_r;
  logic signed [34:0] ll4_r, lh4_r;
  logic signed [53:0] pb4_r, pt4_r;
  logic [16:0]        fy4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (adv) begin
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor4_r <= oor3_r;
      ll4_r  <= dot3_r[0];
      lh4_r  <= dot3_r[1];
      pb4_r  <= $signed({1'b0, fx4}) * dbot;
      pt4_r  <= $signed({1'b0, fx4}) * dtop;
      fy4_r  <= fy4;
    end
  end

  // stage 5: finish x lerps, y lerp product
  logic signed [53:0] rb, rt;
  logic signed [35:0] bot5, top5;
  logic signed [36:0] d5;

  always_comb begin
    rb   = pb4_r + 54'sd32768;
    rt   = pt4_r + 54'sd32768;
    bot5 = 36'(ll4_r) + 36'(rb >>> 16);
    top5 = 36'(lh4_r) + 36'(rt >>> 16);
    d5   = 37'(top5) - 37'(bot5);
  end

  logic               vld5_r, oor5_r;
  logic signed [35:0] bot5_r;
  logic signed [54:0] p5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else if (adv) begin
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oor5_r <= oor4_r;
      bot5_r <= bot5;
      p5_r   <= $signed({1'b0, fy4_r}) * d5;
    end
  end

  // final rounding to Q2.14 and saturation
  logic signed [54:0] r5;
  logic signed [36:0] v1, v1r;
  logic signed [20:0] vq;
  gnpe_out_t          res;

  always_comb begin
    r5  = p5_r + 55'sd32768;
    v1  = 37'(bot5_r) + 37'(r5 >>> 16);
    v1r = v1 + 37'sd32768;
    vq  = 21'(v1r >>> 16);
    if (oor5_r) begin
      res.noise_value = '0;
    end else if (vq > 21'sd32767) begin
      res.noise_value = 16'sh7FFF;
    end else if (vq < -21'sd32768) begin
      res.noise_value = 16'sh8000;
    end else begin
      res.noise_value = vq[15:0];
    end
    res.out_of_range = oor5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld5_r) begin
      out_data_r <= res;
    end
  end

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.out_of_range |-> out_data_r.noise_value == '0)
    else $error("out of range beat with nonzero value");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !head_data.ev |=> !vld1_r) else $error("load entered result pipeline");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled beat changed");

endmodule

/* rtl/gradient_noise_point_eval.sv */
`timescale 1ns / 1ps
// channel  dir  handshake               payload
// in_      in   in_valid / in_stall     gnpe_in_t  in_data
// out_     out  out_valid / out_stall   gnpe_out_t out_data
// cfg_     in   cfg_valid / cfg_ready   cfg_index (1b), cfg_data (16b)
//
// one item per cycle sustained while out_stall is low; out_valid rises once an evaluate is
// accepted and has passed the queue slot, bank read, four arithmetic stages and output
// the four corner reads come from four parity banks of the lattice, one port each
// loads produce no beat; they write the bank when they leave the queue, in order
// in_stall rises only when the 4-entry queue is full; out_stall freezes the back end
// rst_n is synchronous; lattice contents are undefined until loaded
module gradient_noise_point_eval import gnpe_pkg::*; #(
  parameter int CELLS_X = CELLS_X_DEF,
  parameter int CELLS_Y = CELLS_Y_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  gnpe_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output gnpe_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic       task_valid;
  gnpe_task_t task_data;
  logic       head_valid;
  gnpe_task_t head_data;
  logic       pop;

  gnpe_front #(.CELLS_X(CELLS_X), .CELLS_Y(CELLS_Y)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .task_valid(task_valid),
    .task_data (task_data)
  );

  gnpe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(task_valid),
    .push_data (task_data),
    .full      (in_stall),
    .head_valid(head_valid),
    .head_data (head_data),
    .pop       (pop)
  );

  gnpe_back #(.CELLS_X(CELLS_X), .CELLS_Y(CELLS_Y)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_data (head_data),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* dv/gradient_noise_point_eval_tb.sv */
`timescale 1ns / 1ps
module gradient_noise_point_eval_tb;
  import gnpe_pkg::*;

  localparam int NCX = CELLS_X_DEF;
  localparam int NCY = CELLS_Y_DEF;
  localparam int DEPTH = (NCX + 1) * (NCY + 1);
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  gnpe_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  gnpe_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  gradient_noise_point_eval dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic signed [15:0] lat_gx [DEPTH];
  logic signed [15:0] lat_gy [DEPTH];
  bit                 lat_written [DEPTH];
  logic [7:0]         cur_samples;
  logic [15:0]        cur_step;

  gnpe_out_t noise_queue[$];
  int errors;
  int n_items, n_results, n_oor, n_loads;
  int idle_cycles = 0;
  bit hold_off;     // long receiver hold-off
  bit rx_gaps;      // random receiver stalls enabled

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint rnd16(longint v);
    longint w;
    longint q;
    w = v + 32768;
    q = w / 65536;
    if ((w % 65536 != 0) && (w < 0)) q--;
    return q;
  endfunction

  function automatic longint frac_of(int sub);
    longint t;
    t = longint'(sub + 1) * longint'(cur_step);
    return (t > 65535) ? 65535 : t;
  endfunction

  function automatic longint fade_of(longint t);
    longint tt, t2, t3, q, f;
    tt = t * t;
    t2 = (tt + 32768) >>> 16;
    t3 = (t2 * t + 32768) >>> 16;
    q = 655360 - 15 * t + ((6 * tt + 32768) >>> 16);
    f = (t3 * q + 32768) >>> 16;
    return (f > 65536) ? 65536 : f;
  endfunction

  function automatic longint corner_dot(int cx, int cy, longint dx, longint dy);
    int idx;
    idx = cx * (NCY + 1) + cy;
    return longint'(lat_gx[idx]) * dx + longint'(lat_gy[idx]) * dy;
  endfunction

  function automatic longint blend(longint a, longint b, longint f);
    return a + rnd16(f * (b - a));
  endfunction

  // apply one beat to the lattice model, return 1 with the expected noise beat
  function automatic bit predict_noise(gnpe_in_t it, output gnpe_out_t r);
    int split;
    longint tx, ty, fx, fy, ll, lh, hl, hh, bot, top, v;
    r = '0;
    if (it.operation == OP_LOAD) begin
      if (it.cell_x <= NCX && it.cell_y <= NCY) begin
        lat_gx[it.cell_x * (NCY + 1) + it.cell_y] = it.grad_x;
        lat_gy[it.cell_x * (NCY + 1) + it.cell_y] = it.grad_y;
        lat_written[it.cell_x * (NCY + 1) + it.cell_y] = 1'b1;
      end
      return 1'b0;
    end
    split = (cur_samples < MAX_SPLIT) ? cur_samples : MAX_SPLIT;
    if (it.cell_x >= NCX || it.cell_y >= NCY || it.sub_x >= split || it.sub_y >= split) begin
      r.out_of_range = 1'b1;
      return 1'b1;
    end
    tx = frac_of(it.sub_x);
    ty = frac_of(it.sub_y);
    fx = fade_of(tx);
    fy = fade_of(ty);
    ll = corner_dot(it.cell_x, it.cell_y, tx, ty);
    lh = corner_dot(it.cell_x, it.cell_y + 1, tx, ty - 65536);
    hl = corner_dot(it.cell_x + 1, it.cell_y, tx - 65536, ty);
    hh = corner_dot(it.cell_x + 1, it.cell_y + 1, tx - 65536, ty - 65536);
    bot = blend(ll, hl, fx);
    top = blend(lh, hh, fx);
    v = rnd16(blend(bot, top, fy));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    r.noise_value = v[15:0];
    return 1'b1;
  endfunction

  function automatic bit corners_loaded(int cx, int cy);
    return lat_written[cx * (NCY + 1) + cy] && lat_written[cx * (NCY + 1) + cy + 1] &&
           lat_written[(cx + 1) * (NCY + 1) + cy] &&
           lat_written[(cx + 1) * (NCY + 1) + cy + 1];
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) :
           (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
  endfunction

  // send one beat; prediction happens at acceptance
  task automatic send_item(gnpe_in_t it, bit gaps = 1'b1);
    gnpe_out_t r;
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_noise(it, r)) noise_queue.push_back(r);
    n_items++;
    if (it.operation == OP_LOAD) n_loads++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_SAMPLES) cur_samples = val[7:0];
    else cur_step = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (noise_queue.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic gnpe_in_t load_item(int cx, int cy, int gx, int gy);
    gnpe_in_t it;
    it = '0;
    it.operation = OP_LOAD;
    it.cell_x = cx[4:0];
    it.cell_y = cy[4:0];
    it.grad_x = gx[15:0];
    it.grad_y = gy[15:0];
    it.sub_x = 8'($urandom);
    it.sub_y = 8'($urandom);
    return it;
  endfunction

  function automatic gnpe_in_t eval_item(int cx, int cy, int sx, int sy);
    gnpe_in_t it;
    it = '0;
    it.operation = OP_EVAL;
    it.cell_x = cx[4:0];
    it.cell_y = cy[4:0];
    it.sub_x = sx[7:0];
    it.sub_y = sy[7:0];
    it.grad_x = 16'($urandom);
    it.grad_y = 16'($urandom);
    return it;
  endfunction

  function automatic int rand_grad();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return -16384;
    if (k == 1) return 16384;
    return $urandom_range(0, 32768) - 16384;
  endfunction

  task automatic test_fill_lattice();
    for (int x = 0; x <= NCX; x++)
      for (int y = 0; y <= NCY; y++)
        send_item(load_item(x, y, rand_grad(), rand_grad()), 1'b0);
  endtask

  task automatic test_directed();
    // extreme gradients on cell 0, 0 then evaluate at the default spacing
    send_item(load_item(0, 0, 16384, 16384));
    send_item(load_item(0, 1, -16384, 16384));
    send_item(load_item(1, 0, 16384, -16384));
    send_item(load_item(1, 1, -16384, -16384));
    send_item(load_item(NCX, NCY, -16384, 16384));
    // load outside the lattice is dropped
    send_item(load_item(NCX + 1, 3, 1234, 5678));
    send_item(load_item(2, 31, 1234, 5678));
    send_item(eval_item(0, 0, 0, 0));
    send_item(eval_item(0, 0, 1, 1));
    send_item(eval_item(0, 0, 0, 1));
    send_item(eval_item(NCX - 1, NCY - 1, 1, 0));
    // out of range cells and subs
    send_item(eval_item(NCX, 0, 0, 0));
    send_item(eval_item(0, NCY, 0, 0));
    send_item(eval_item(31, 31, 255, 255));
    send_item(eval_item(0, 0, 2, 0));
    send_item(eval_item(0, 0, 0, 2));
    drain();
    // zero sub-samples: every point is out of range
    write_reg(REG_SAMPLES, 16'd0);
    send_item(eval_item(0, 0, 0, 0));
    drain();
    // widest split with a step of 32768 saturates the fraction
    write_reg(REG_SAMPLES, 16'd255);
    write_reg(REG_STEP, 16'd32768);
    send_item(eval_item(0, 0, 0, 0));
    send_item(eval_item(0, 0, 1, 254));
    send_item(eval_item(NCX - 1, NCY - 1, 254, 254));
    send_item(eval_item(0, 0, 255, 0));
    drain();
    write_reg(REG_STEP, 16'd1);
    send_item(eval_item(3, 4, 0, 254));
    drain();
  endtask

  task automatic random_phase(int count, int max_sub);
    int k;
    int cx, cy;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 9);
      cx = $urandom_range(0, NCX - 1);
      cy = $urandom_range(0, NCY - 1);
      if (k < 2) begin
        send_item(load_item($urandom_range(0, 31), $urandom_range(0, 31),
                            rand_grad(), rand_grad()));
      end else if (k == 2) begin
        // noise: any cell and sub, but only where corners are defined
        cx = $urandom_range(0, 31);
        cy = $urandom_range(0, 31);
        if (cx < NCX && cy < NCY && !corners_loaded(cx, cy)) cx = NCX + cx % 16;
        send_item(eval_item(cx, cy, $urandom, $urandom));
      end else begin
        send_item(eval_item(cx, cy, $urandom_range(0, max_sub), $urandom_range(0, max_sub)));
      end
    end
    drain();
  endtask

  task automatic test_random_settings();
    int sps;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: sps = 1;
        1: sps = 255;
        default: sps = $urandom_range(1, 20);
      endcase
      write_reg(REG_SAMPLES, 16'(sps));
      if (p == 4) write_reg(REG_STEP, 16'($urandom_range(1, 32768)));
      else write_reg(REG_STEP, 16'(65536 / (sps + 1)));
      random_phase(240, (sps > 1) ? sps - 1 : 0);
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_SAMPLES, 16'd4);
    write_reg(REG_STEP, 16'd13107);
    hold_off = 1'b1;
    for (int i = 0; i < 40; i++)
      send_item(eval_item($urandom_range(0, NCX - 1), $urandom_range(0, NCY - 1),
                          $urandom_range(0, 3), $urandom_range(0, 3)), 1'b0);
    drain();
  endtask

  // receiver: random stalls, plus one long hold-off
  initial begin
    int g;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 2);
        out_stall <= 1'b1;
        repeat (g) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    gnpe_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (noise_queue.size() == 0) begin
        $display("%0t: unexpected noise beat %h", $time, out_data);
        errors++;
      end else begin
        want = noise_queue.pop_front();
        if (out_data.out_of_range) n_oor++;
        if (out_data.noise_value !== want.noise_value) begin
          $display("%0t: noise_value expected %0d actual %0d", $time,
                   want.noise_value, out_data.noise_value);
          errors++;
        end
        if (out_data.out_of_range !== want.out_of_range) begin
          $display("%0t: out_of_range expected %0b actual %0b", $time,
                   want.out_of_range, out_data.out_of_range);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", noise_queue.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    errors = 0;
    n_items = 0;
    n_results = 0;
    n_oor = 0;
    n_loads = 0;
    hold_off = 1'b0;
    rx_gaps = 1'b0;
    cur_samples = SAMPLES_RST;
    cur_step = STEP_RST;
    for (int i = 0; i < DEPTH; i++) begin
      lat_gx[i] = '0;
      lat_gy[i] = '0;
      lat_written[i] = 1'b0;
    end
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SAMPLES;
    cfg_data = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    rx_gaps = 1'b1;
    test_fill_lattice();
    test_directed();
    test_random_settings();
    test_backpressure();
    drain();
    $display("covered %0d input beats (%0d loads), %0d noise beats, %0d out of range",
             n_items, n_loads, n_results, n_oor);
    $display("settings: samples 0/1/255 and random, steps 1 to 32768, long output hold-off");
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
